/* hdl/aeg_pkg.sv */
// ----------------------------------------------------------------------------
// aeg_pkg: shared types and constants for the ADSR envelope gain stage
// Transaction payloads, gain format and configuration register indexes.
// ----------------------------------------------------------------------------
package aeg_pkg;

    // Sample and gain formats (gain is unsigned Q1.14)
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 15;
    localparam int GAIN_SHIFT  = 14;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 15'd16384;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_END = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DURATION  = 3'd4;

    // Reset values
    localparam logic [GAIN_BITS-1:0] SUSTAIN_RESET  = UNITY_GAIN;
    localparam int                   DURATION_RESET = 44100;

    // Input transaction
    typedef struct packed {
        logic                          start_req;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } t_env_in;

    // Output transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last;
    } t_env_out;

endpackage

/* hdl/aeg_serial_mul.sv */
// ----------------------------------------------------------------------------
// aeg_serial_mul: shift-add multiplier, one multiplier bit per cycle
// A (signed or unsigned) times unsigned B.
// ----------------------------------------------------------------------------
module aeg_serial_mul #(
    parameter int A_BITS = 24,
    parameter int B_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_signed,
    input  logic [A_BITS-1:0]          i_a,
    input  logic [B_BITS-1:0]          i_b,
    output logic                       o_done,
    output logic [A_BITS+B_BITS-1:0]   o_prod
);

    localparam int P_BITS   = A_BITS + B_BITS;
    localparam int CNT_BITS = $clog2(B_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_signed;
    logic [A_BITS-1:0]   r_a;
    logic [P_BITS-1:0]   r_prod;

    logic              n_ext_p;
    logic              n_ext_a;
    logic [A_BITS:0]   n_add;
    logic [A_BITS:0]   n_upper;
    logic [P_BITS-1:0] n_prod;

    // Upper half accumulates, low half shifts out the multiplier bits
    always_comb begin
        n_ext_p = r_signed & r_prod[P_BITS-1];
        n_ext_a = r_signed & r_a[A_BITS-1];
        n_add   = {n_ext_a, r_a} & {(A_BITS+1){r_prod[0]}};
        n_upper = {n_ext_p, r_prod[P_BITS-1:B_BITS]} + n_add;
        n_prod  = {n_upper, r_prod[B_BITS-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(B_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a      <= i_a;
            r_signed <= i_signed;
            r_prod   <= P_BITS'(i_b);
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* hdl/aeg_serial_div.sv */
// ----------------------------------------------------------------------------
// aeg_serial_div: restoring divider, one quotient bit per cycle
// Caller guarantees num < den * 2**QUO_BITS and den != 0.
// ----------------------------------------------------------------------------
module aeg_serial_div #(
    parameter int NUM_BITS = 39,
    parameter int DEN_BITS = 24,
    parameter int QUO_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0] r_lo;

    logic [DEN_BITS:0]   n_shift;
    logic [DEN_BITS:0]   n_trial;
    logic                n_qbit;
    logic [DEN_BITS-1:0] n_rem;
    logic [QUO_BITS-1:0] n_lo;

    // Trial subtract; the low register trades numerator bits for quotient bits
    always_comb begin
        n_shift = {r_rem, r_lo[QUO_BITS-1]};
        n_trial = n_shift - {1'b0, r_den};
        n_qbit  = ~n_trial[DEN_BITS];
        n_rem   = n_qbit ? n_trial[DEN_BITS-1:0] : n_shift[DEN_BITS-1:0];
        n_lo    = {r_lo[QUO_BITS-2:0], n_qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(QUO_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[DEN_BITS+QUO_BITS-1:QUO_BITS];
            r_lo  <= i_num[QUO_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;

endmodule

/* hdl/linear_adsr_envelope_gain.sv */
// ----------------------------------------------------------------------------
// linear_adsr_envelope_gain: linear ADSR envelope applied to a sample stream
// Per-note sample counter selects a Q1.14 gain; sample times gain, floored
// and saturated.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  -------------------------------
// in       sink       i_in_valid/o_in_stall   t_env_in  {start_req, sample_in}
// out      source     o_out_valid/i_out_stall t_env_out {sample_out, last}
// cfg      sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Flow: one input transaction at a time. Sustain and the past-end tail
//   need only the sample * gain product, attack adds a division, decay
//   and release a ramp product and a division. The 15-step shift-add
//   multiplier and 15-step restoring divider give one gain bit per cycle.
// Reset: synchronous, active low; registers take their listed defaults and
//   the sample counter clears.
// Stalls: a finished result waits in the output register; the next input
//   transaction is taken meanwhile and its result waits in the sequencer.
// ----------------------------------------------------------------------------
module linear_adsr_envelope_gain #(
    parameter int TIME_BITS = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  aeg_pkg::t_env_in           i_in_data,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output aeg_pkg::t_env_out          o_out_data,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [aeg_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [((TIME_BITS > aeg_pkg::GAIN_BITS) ? TIME_BITS
                                                   : aeg_pkg::GAIN_BITS)-1:0] i_cfg_data
);

    import aeg_pkg::*;

    // Duration holds at least 16 bits so its default always fits
    localparam int DUR_BITS   = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int CMP_BITS   = DUR_BITS + 1;
    localparam int MUL_A_BITS = DUR_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + GAIN_BITS;
    localparam int Y_BITS     = PROD_BITS - GAIN_SHIFT;

    localparam logic signed [Y_BITS-1:0] Y_HI = Y_BITS'((2**(SAMPLE_BITS-1)) - 1);
    localparam logic signed [Y_BITS-1:0] Y_LO = Y_BITS'(-(2**(SAMPLE_BITS-1)));

    // Sequencer states
    localparam int STATE_BITS = 3;
    localparam logic [STATE_BITS-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_BITS-1:0] S_PHASE = 3'd1;  // classify t
    localparam logic [STATE_BITS-1:0] S_SETUP = 3'd2;  // launch first unit or load a direct gain
    localparam logic [STATE_BITS-1:0] S_MUL1  = 3'd3;  // ramp numerator product
    localparam logic [STATE_BITS-1:0] S_DIV   = 3'd4;  // ramp division
    localparam logic [STATE_BITS-1:0] S_GAIN  = 3'd5;  // launch sample * gain
    localparam logic [STATE_BITS-1:0] S_MULF  = 3'd6;
    localparam logic [STATE_BITS-1:0] S_OUT   = 3'd7;  // saturate, hand over

    // Envelope phases
    localparam logic [2:0] PH_ATTACK  = 3'd0;
    localparam logic [2:0] PH_DECAY   = 3'd1;
    localparam logic [2:0] PH_RELEASE = 3'd2;
    localparam logic [2:0] PH_ZERO    = 3'd3;  // release past the note end
    localparam logic [2:0] PH_SUSTAIN = 3'd4;

    // Configuration registers
    logic [TIME_BITS-1:0] r_attack;
    logic [TIME_BITS-1:0] r_decay_end;
    logic [GAIN_BITS-1:0] r_sustain;
    logic [TIME_BITS-1:0] r_release;
    logic [DUR_BITS-1:0]  r_duration;

    // Control
    logic [STATE_BITS-1:0] r_state;
    logic [STATE_BITS-1:0] n_state;
    logic [TIME_BITS-1:0]  r_sample_counter;
    logic                  r_out_valid;

    // Per-transaction payload
    logic [TIME_BITS-1:0]          r_t;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [2:0]                    r_phase;
    logic [2:0]                    n_phase;
    logic [GAIN_BITS-1:0]          r_gain;
    logic [GAIN_BITS-1:0]          n_gain;
    t_env_out                      r_out_data;

    logic                 in_accept;
    logic                 out_free;
    logic [TIME_BITS-1:0] n_t;

    // Datapath helpers
    logic [TIME_BITS-1:0]            w_t_minus_a;
    logic [TIME_BITS-1:0]            w_dk_minus_a;
    logic [DUR_BITS-1:0]             w_d_minus_t;
    logic [TIME_BITS:0]              w_t_plus_r;
    logic [TIME_BITS+GAIN_SHIFT-1:0] w_t_scaled;
    logic                            w_sus_below;
    logic [GAIN_BITS-1:0]            w_decay_span;
    logic [GAIN_BITS-1:0]            w_sus_eff;
    logic signed [Y_BITS-1:0]        w_y;
    logic [SAMPLE_BITS-1:0]          w_sample;
    logic                            w_last;

    // Unit hookup
    logic                  mul_start;
    logic                  mul_signed;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [GAIN_BITS-1:0]  mul_b;
    logic                  mul_done;
    logic [PROD_BITS-1:0]  mul_prod;

    logic                  div_start;
    logic [PROD_BITS-1:0]  div_num;
    logic [TIME_BITS-1:0]  div_den;
    logic                  div_done;
    logic [GAIN_BITS-1:0]  div_quo;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack    <= '0;
            r_decay_end <= '0;
            r_sustain   <= SUSTAIN_RESET;
            r_release   <= '0;
            r_duration  <= DUR_BITS'(DURATION_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ATTACK:    r_attack    <= i_cfg_data[TIME_BITS-1:0];
                CFG_DECAY_END: r_decay_end <= i_cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN:   r_sustain   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RELEASE:   r_release   <= i_cfg_data[TIME_BITS-1:0];
                CFG_DURATION:  r_duration  <= DUR_BITS'(i_cfg_data[TIME_BITS-1:0]);
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Envelope arithmetic
    // ------------------------------------------------------------------
    assign n_t          = i_in_data.start_req ? '0 : r_sample_counter;
    assign w_t_minus_a  = r_t - r_attack;
    assign w_dk_minus_a = r_decay_end - r_attack;
    assign w_d_minus_t  = r_duration - DUR_BITS'(r_t);
    assign w_t_plus_r   = {1'b0, r_t} + {1'b0, r_release};
    assign w_t_scaled   = {r_t, {GAIN_SHIFT{1'b0}}};
    assign w_sus_below  = (r_sustain < UNITY_GAIN);
    // decay runs toward sustain from either side of unity
    assign w_decay_span = w_sus_below ? (UNITY_GAIN - r_sustain) : (r_sustain - UNITY_GAIN);
    // zero sustain ramps down from unity in release
    assign w_sus_eff    = (r_sustain == '0) ? UNITY_GAIN : r_sustain;

    // First match wins: attack, decay, release, sustain
    always_comb begin
        priority if (r_t < r_attack) begin
            n_phase = PH_ATTACK;
        end else if (r_t < r_decay_end) begin
            n_phase = PH_DECAY;
        end else if ((r_release != '0) &&
                     (CMP_BITS'(w_t_plus_r) > CMP_BITS'(r_duration))) begin
            n_phase = (DUR_BITS'(r_t) >= r_duration) ? PH_ZERO : PH_RELEASE;
        end else begin
            n_phase = PH_SUSTAIN;
        end
    end

    // Multiplier: ramp numerator during decay/release, then sample * gain
    assign mul_start  = ((r_state == S_SETUP) &&
                         ((r_phase == PH_DECAY) || (r_phase == PH_RELEASE))) ||
                        (r_state == S_GAIN);
    assign mul_signed = (r_state == S_GAIN);

    always_comb begin
        priority if (r_state == S_GAIN) begin
            mul_a = MUL_A_BITS'(r_x);
            mul_b = r_gain;
        end else if (r_phase == PH_DECAY) begin
            mul_a = MUL_A_BITS'(w_t_minus_a);
            mul_b = w_decay_span;
        end else begin
            mul_a = w_d_minus_t;
            mul_b = w_sus_eff;
        end
    end

    // Divider: attack takes t << 14 directly, decay/release the product
    assign div_start = ((r_state == S_SETUP) && (r_phase == PH_ATTACK)) ||
                       ((r_state == S_MUL1) && mul_done);
    assign div_num   = (r_state == S_SETUP) ? PROD_BITS'(w_t_scaled) : mul_prod;

    always_comb begin
        priority if (r_phase == PH_ATTACK) begin
            div_den = r_attack;
        end else if (r_phase == PH_DECAY) begin
            div_den = w_dk_minus_a;
        end else begin
            div_den = r_release;
        end
    end

    aeg_serial_mul #(
        .A_BITS (MUL_A_BITS),
        .B_BITS (GAIN_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_signed (mul_signed),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    aeg_serial_div #(
        .NUM_BITS (PROD_BITS),
        .DEN_BITS (TIME_BITS),
        .QUO_BITS (GAIN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Gain register: direct for sustain/zero, from the quotient otherwise
    always_comb begin
        n_gain = r_gain;
        if (r_state == S_SETUP) begin
            if (r_phase == PH_ZERO) begin
                n_gain = '0;
            end else if (r_phase == PH_SUSTAIN) begin
                n_gain = r_sustain;
            end
        end else if ((r_state == S_DIV) && div_done) begin
            if (r_phase == PH_DECAY) begin
                n_gain = w_sus_below ? (UNITY_GAIN - div_quo) : (UNITY_GAIN + div_quo);
            end else begin
                n_gain = div_quo;
            end
        end
    end

    // Arithmetic shift floors; then clamp to the sample range
    assign w_y = mul_prod[PROD_BITS-1:GAIN_SHIFT];

    always_comb begin
        priority if (w_y > Y_HI) begin
            w_sample = Y_HI[SAMPLE_BITS-1:0];
        end else if (w_y < Y_LO) begin
            w_sample = Y_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sample = w_y[SAMPLE_BITS-1:0];
        end
    end

    // Counter already holds the post-sample value here
    assign w_last = (DUR_BITS'(r_sample_counter) >= r_duration);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_accept) n_state = S_PHASE;
            S_PHASE: n_state = S_SETUP;
            S_SETUP: begin
                if (r_phase == PH_ATTACK) begin
                    n_state = S_DIV;
                end else if ((r_phase == PH_DECAY) || (r_phase == PH_RELEASE)) begin
                    n_state = S_MUL1;
                end else begin
                    n_state = S_GAIN;
                end
            end
            S_MUL1:  if (mul_done) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_GAIN;
            S_GAIN:  n_state = S_MULF;
            S_MULF:  if (mul_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_sample_counter <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                // saturating count, so last holds after the note ends
                r_sample_counter <= (&n_t) ? n_t : (n_t + 1'b1);
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_t <= n_t;
            r_x <= i_in_data.sample_in;
        end
        if (r_state == S_PHASE) begin
            r_phase <= n_phase;
        end
        r_gain <= n_gain;
        if ((r_state == S_OUT) && out_free) begin
            r_out_data.sample_out <= w_sample;
            r_out_data.last       <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // A new result only ever comes out of the hand-over state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output valid rose outside hand-over");

    // Attack ramp stays strictly below unity
    a_attack_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GAIN) && (r_phase == PH_ATTACK)) |-> (r_gain < UNITY_GAIN))
        else $error("attack gain reached unity");

    // The divider is never launched with a zero divisor
    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (div_den != '0))
        else $error("divider started with zero divisor");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for linear_adsr_envelope_gain
// Streams random samples through the envelope stage under many register
// settings and compares every output transaction against an in-bench model
// of the ADSR gain, the floor shift and the 16-bit saturation.
// ----------------------------------------------------------------------------
module tb_top;
    import aeg_pkg::*;

    localparam int TIME_BITS     = 24;
    localparam int CFG_DATA_BITS = (TIME_BITS > GAIN_BITS) ? TIME_BITS : GAIN_BITS;
    localparam longint TIME_MAX  = (longint'(1) << TIME_BITS) - 1;
    localparam longint UNITY     = longint'(UNITY_GAIN);
    localparam longint SMP_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN   = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 64;      // > worst accept-to-result latency
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 144;     // 12 x 144 + 25 directed ~ 1750
    localparam int MAX_PRINTS    = 100;

    // Envelope segment the gain came from, tallied for the summary
    typedef enum int {
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN,
        SEG_RELEASE,
        SEG_ENDED
    } t_env_seg;
    localparam int NUM_SEGS = 5;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, note sample counter, expected outputs
    // ------------------------------------------------------------------------
    class adsr_scoreboard;
        longint   attack_len;
        longint   decay_end;
        longint   sustain;
        longint   release_len;
        longint   duration;
        longint   note_time;
        t_env_out want_q[$];
        int       errors;
        int       compared;
        int       seg_hits[NUM_SEGS];

        function new();
            attack_len  = 0;
            decay_end   = 0;
            sustain     = longint'(SUSTAIN_RESET);
            release_len = 0;
            duration    = longint'(DURATION_RESET);
            note_time   = 0;
            errors      = 0;
            compared    = 0;
            foreach (seg_hits[i]) seg_hits[i] = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_ATTACK:    attack_len  = longint'(val[TIME_BITS-1:0]);
                CFG_DECAY_END: decay_end   = longint'(val[TIME_BITS-1:0]);
                CFG_SUSTAIN:   sustain     = longint'(val[GAIN_BITS-1:0]);
                CFG_RELEASE:   release_len = longint'(val[TIME_BITS-1:0]);
                CFG_DURATION:  duration    = longint'(val[TIME_BITS-1:0]);
                default: ;
            endcase
        endfunction

        // Q1.14 gain at sample index t; first matching segment wins
        function longint gain_at(longint t, output t_env_seg seg);
            longint lvl;
            if (t < attack_len) begin
                seg = SEG_ATTACK;
                return (t * UNITY) / attack_len;
            end
            if (t < decay_end) begin
                // signed divide truncates toward zero, ramp heads to sustain
                seg = SEG_DECAY;
                return UNITY + ((sustain - UNITY) * (t - attack_len))
                               / (decay_end - attack_len);
            end
            if (release_len != 0 && t + release_len > duration) begin
                lvl = (sustain == 0) ? UNITY : sustain;   // zero sustain acts as unity
                if (t >= duration) begin
                    seg = SEG_ENDED;
                    return 0;
                end
                seg = SEG_RELEASE;
                return (lvl * (duration - t)) / release_len;
            end
            seg = SEG_SUSTAIN;
            return sustain;
        endfunction

        // Accepted input transaction: advance the note and queue its output
        function void note_input(t_env_in item);
            longint   x;
            longint   y;
            t_env_seg seg;
            t_env_out want;
            if (item.start_req)
                note_time = 0;
            x = longint'(item.sample_in);
            y = (x * gain_at(note_time, seg)) >>> GAIN_SHIFT;   // floor
            if (y > SMP_MAX) y = SMP_MAX;
            if (y < SMP_MIN) y = SMP_MIN;
            if (note_time < TIME_MAX)
                note_time++;
            want.sample_out = y[SAMPLE_BITS-1:0];
            want.last       = (note_time >= duration);
            want_q.push_back(want);
            seg_hits[seg]++;
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_output(t_env_out got);
            t_env_out want;
            if (want_q.size() == 0) begin
                report_mismatch($sformatf("output %h with nothing pending", got));
                return;
            end
            want = want_q.pop_front();
            compared++;
            if (got.sample_out !== want.sample_out)
                report_mismatch($sformatf("output %0d sample_out %0d, expected %0d",
                                          compared, got.sample_out, want.sample_out));
            if (got.last !== want.last)
                report_mismatch($sformatf("output %0d last %b, expected %b",
                                          compared, got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    t_env_in                       i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    t_env_out                      o_out_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data  = '0;

    adsr_scoreboard sb;

    int  send_idle_pct = 34;     // chance per cycle that the sender idles
    int  recv_idle_pct = 83;     // chance per cycle that the receiver stalls
    logic hold_active  = 1'b0;   // long receiver hold-off in progress
    int  cycle_count   = 0;
    int  items_sent    = 0;
    int  settings_used = 0;

    linear_adsr_envelope_gain #(
        .TIME_BITS(TIME_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: fails and stops the run once the cycle limit is reached
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs pending",
                     cycle_count, sb.want_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: values seen here are the ones present at the edge, so an
    // output transaction is counted when valid was high and our stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_output(o_out_data);
        i_out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One register write; valid stays up so back-to-back writes need no gap
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, val);
    endtask

    // Full register set; only called with no output transaction outstanding
    task automatic program_envelope(int unsigned atk, int unsigned dec_end,
                                    int unsigned sus, int unsigned rel,
                                    int unsigned dur);
        write_register(CFG_ATTACK,    CFG_DATA_BITS'(atk));
        write_register(CFG_DECAY_END, CFG_DATA_BITS'(dec_end));
        write_register(CFG_SUSTAIN,   CFG_DATA_BITS'(sus));
        write_register(CFG_RELEASE,   CFG_DATA_BITS'(rel));
        write_register(CFG_DURATION,  CFG_DATA_BITS'(dur));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Offer one sample; returns at the edge that accepted it. Valid is only
    // dropped when an idle gap is taken, so it is never lowered and raised
    // in the same step.
    task automatic send_sample(logic start, logic [SAMPLE_BITS-1:0] smp);
        t_env_in item;
        item.start_req = start;
        item.sample_in = smp;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(item);
        items_sent++;
    endtask

    // Stop offering and wait for every pending output transaction
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (sb.want_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic hold_receiver(int cycles);
        hold_active <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active <= 1'b0;
    endtask

    // Mostly full-scale random audio, with the rails and values near zero
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(2)) - 1);   // -1, 0 or 1
            default: return 16'($urandom);
        endcase
    endfunction

    // Notes run up to four past min(duration, 60) so release, the end flag and
    // the zero-gain tail all get exercised. A few notes skip the start flag
    // and a few restart mid-note, to mix in broken sequences. The last note
    // is cut short so the phase sends exactly its quota.
    task automatic run_notes(int unsigned dur, int quota);
        int count;
        int len;
        logic start;
        count = 0;
        while (count < quota) begin
            len = ((dur > 60) ? 60 : int'(dur)) + $urandom_range(4);
            if (len > quota - count)
                len = quota - count;
            for (int i = 0; i < len; i++) begin
                if (i == 0)
                    start = ($urandom_range(9) != 0);
                else
                    start = ($urandom_range(99) < 3);
                send_sample(start, pick_sample());
            end
            count += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned dur, atk, dec_end, sus, rel;

        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (unity sustain): output equals input, rails included
        program_envelope(0, 0, 32'(UNITY_GAIN), 0, DURATION_RESET);
        send_sample(1'b1, 16'h7FFF);
        send_sample(1'b0, 16'h8000);
        send_sample(1'b0, 16'h0000);
        send_sample(1'b0, 16'hFFFF);
        send_sample(1'b0, 16'h0001);
        drain_outputs();

        // Short note through attack, decay toward a sustain above unity
        // (saturating), release and the zero-gain tail past the end
        program_envelope(4, 8, 32767, 6, 12);
        for (int i = 0; i < 14; i++)
            send_sample(i == 0, (i % 2) ? 16'h8000 : 16'h7FFF);
        drain_outputs();

        // Zero sustain treated as unity in release, release longer than note
        program_envelope(0, 0, 0, 20, 6);
        for (int i = 0; i < 4; i++)
            send_sample(i == 0, (i % 2) ? 16'h8000 : 16'h7FFF);
        drain_outputs();

        // Zero duration: end flag on every output
        program_envelope(0, 0, 32'(UNITY_GAIN), 0, 0);
        send_sample(1'b1, 16'h4000);
        send_sample(1'b0, 16'hC000);
        drain_outputs();

        // Phases: a new register set each (first two fixed, rest random), idling pattern by thirds
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 83;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 0) begin
                // every register at its top value
                dur = 32'(TIME_MAX); atk = 32'(TIME_MAX); dec_end = 32'(TIME_MAX);
                sus = 32767;         rel = 32'(TIME_MAX);
            end else if (p == 1) begin
                // bottom values, one-sample note
                dur = 1; atk = 0; dec_end = 0; sus = 0; rel = 0;
            end else begin
                dur     = $urandom_range(48, 1);
                atk     = $urandom_range(dur, 0);
                dec_end = $urandom_range(dur + 4, 0);
                case ($urandom_range(3))
                    0:       sus = 0;
                    1:       sus = 32'(UNITY_GAIN);
                    2:       sus = 32767;
                    default: sus = $urandom_range(32767);
                endcase
                rel = ($urandom_range(3) == 0) ? 0 : $urandom_range(dur + 10, 1);
            end
            program_envelope(atk, dec_end, sus, rel, dur);

            // One phase keeps the receiver off for a long stretch while
            // samples keep coming, so the block backs up and stalls its input
            if (p == 5) begin
                fork
                    hold_receiver(400);
                    run_notes(dur, PHASE_ITEMS);
                join
            end else begin
                run_notes(dur, PHASE_ITEMS);
            end
            drain_outputs();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d samples under %0d register settings, %0d outputs compared",
                 items_sent, settings_used, sb.compared);
        $display("gain segments: attack %0d, decay %0d, sustain %0d, release %0d, ended %0d",
                 sb.seg_hits[SEG_ATTACK], sb.seg_hits[SEG_DECAY],
                 sb.seg_hits[SEG_SUSTAIN], sb.seg_hits[SEG_RELEASE],
                 sb.seg_hits[SEG_ENDED]);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
